// ----- sv/hcp_pkg.sv -----
// Shared types, constants and helpers of the HSL colorize pixel pipeline.
`default_nettype none
package hcp_pkg;

	localparam int unsigned FRACTION_BITS_DEF = 16;

	// floor(2^32 / 60), used to divide by 60 through a multiply
	localparam logic [26:0] RECIP_60 = 27'd71582788;
	localparam int unsigned RECIP_SHIFT = 32;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [8:0] sat;
		logic [9:0] offset;
	} hsl_cfg_t;

	typedef enum logic [1:0] {
		CFG_INFLUENCE = 2'd0,
		CFG_HUE       = 2'd1,
		CFG_SATURATION = 2'd2,
		CFG_LIGHTNESS = 2'd3
	} cfg_idx_t;

	// weight of (q - p) in sixtieths for a channel hue in degrees
	function automatic logic [5:0] hue_weight(input logic [8:0] t);
		logic [8:0] dn;
		dn = 9'd240 - t;
		if (t < 9'd60) return t[5:0];
		else if (t < 9'd180) return 6'd60;
		else if (t < 9'd240) return dn[5:0];
		else return 6'd0;
	endfunction

endpackage
`default_nettype wire

// ----- sv/hcp_unpremul.sv -----
// Unpremultiply pipeline: max/min channel divided by alpha, one quotient bit per stage.
`default_nettype none
module hcp_unpremul import hcp_pkg::*; #(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire pix_t                   in_pix,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output pix_t                        out_pix,
	output logic [FRACTION_BITS:0]      out_umax,
	output logic [FRACTION_BITS:0]      out_umin
);

	localparam int unsigned F = FRACTION_BITS;
	localparam int unsigned N = F + 1;

	logic         v_s   [N];
	pix_t         pix_s [N];
	logic [7:0]   rmx_s [N];
	logic [7:0]   rmn_s [N];
	logic [F-1:0] qmx_s [N];
	logic [F-1:0] qmn_s [N];
	logic         cmx_s [N];
	logic         cmn_s [N];

	logic [N:0]   ld;
	logic [7:0]   mx, mn;
	logic         fmx, fmn;
	logic [7:0]   nrmx [N];
	logic [7:0]   nrmn [N];
	logic         bmx  [N];
	logic         bmn  [N];

	always_comb begin
		ld[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			ld[k] = !v_s[k] || ld[k+1];
		end
	end
	assign in_ready = ld[0];

	always_comb begin
		mx = in_pix.red;
		if (in_pix.green > mx) mx = in_pix.green;
		if (in_pix.blue > mx) mx = in_pix.blue;
		mn = in_pix.red;
		if (in_pix.green < mn) mn = in_pix.green;
		if (in_pix.blue < mn) mn = in_pix.blue;
		// channel at or above alpha clamps to one
		fmx = mx >= in_pix.alpha;
		fmn = mn >= in_pix.alpha;
	end

	// restoring division step per stage; remainder stays below alpha
	always_comb begin
		logic [8:0] r2x, r2n, a9;
		nrmx[0] = '0;
		nrmn[0] = '0;
		bmx[0]  = 1'b0;
		bmn[0]  = 1'b0;
		for (int k = 1; k < N; k++) begin
			a9  = {1'b0, pix_s[k-1].alpha};
			r2x = {rmx_s[k-1], 1'b0};
			r2n = {rmn_s[k-1], 1'b0};
			bmx[k]  = r2x >= a9;
			bmn[k]  = r2n >= a9;
			nrmx[k] = bmx[k] ? 8'(r2x - a9) : r2x[7:0];
			nrmn[k] = bmn[k] ? 8'(r2n - a9) : r2n[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s[k] <= 1'b0;
		end else begin
			if (ld[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (ld[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			pix_s[0] <= in_pix;
			rmx_s[0] <= fmx ? 8'd0 : mx;
			rmn_s[0] <= fmn ? 8'd0 : mn;
			qmx_s[0] <= '0;
			qmn_s[0] <= '0;
			cmx_s[0] <= fmx;
			cmn_s[0] <= fmn;
		end
		for (int k = 1; k < N; k++) begin
			if (ld[k]) begin
				pix_s[k] <= pix_s[k-1];
				rmx_s[k] <= nrmx[k];
				rmn_s[k] <= nrmn[k];
				qmx_s[k] <= {qmx_s[k-1][F-2:0], bmx[k]};
				qmn_s[k] <= {qmn_s[k-1][F-2:0], bmn[k]};
				cmx_s[k] <= cmx_s[k-1];
				cmn_s[k] <= cmn_s[k-1];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_pix   = pix_s[N-1];
	assign out_umax  = cmx_s[N-1] ? {1'b1, {F{1'b0}}} : {1'b0, qmx_s[N-1]};
	assign out_umin  = cmn_s[N-1] ? {1'b1, {F{1'b0}}} : {1'b0, qmn_s[N-1]};

endmodule
`default_nettype wire

// ----- sv/hcp_hsl.sv -----
// Lightness shift and HSL-to-RGB rebuild, six pipeline stages.
`default_nettype none
module hcp_hsl import hcp_pkg::*; #(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hsl_cfg_t               cfg,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire pix_t                   in_pix,
	input  wire logic [FRACTION_BITS:0] in_umax,
	input  wire logic [FRACTION_BITS:0] in_umin,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output pix_t                        out_pix,
	output logic [FRACTION_BITS:0]      out_col [3]
);

	localparam int unsigned F  = FRACTION_BITS;
	localparam int unsigned XW = F + 7;
	localparam int unsigned YW = XW + 27;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld1, ld2, ld3, ld4, ld5, ld6;

	pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6;
	logic [F:0]    l_s1;
	logic [F:0]    l_s2, q_s2;
	logic [F:0]    p_s3, d_s3;
	logic [5:0]    k_s3 [3];
	logic [F:0]    p_s4;
	logic [XW-1:0] x_s4 [3];
	logic [F:0]    p_s5;
	logic [XW-1:0] x_s5 [3];
	logic [YW-1:0] y_s5 [3];
	logic [F:0]    c_s6 [3];

	assign ld6 = !v_s6 || out_ready;
	assign ld5 = !v_s5 || ld6;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign in_ready = ld1;

	// stage 1: lightness plus offset, clamped to [0, one]
	logic [F+1:0]        lsum;
	logic signed [F+2:0] lsh, offs;
	logic [F:0]          lcl;
	always_comb begin
		lsum = (F+2)'(in_umax) + (F+2)'(in_umin);
		offs = {cfg.offset[9], cfg.offset, {(F-8){1'b0}}};
		lsh  = $signed({2'b00, lsum[F+1:1]}) + offs;
		if (lsh[F+2]) lcl = '0;
		else if (lsh > $signed((F+3)'(1) <<< F)) lcl = {1'b1, {F{1'b0}}};
		else lcl = lsh[F:0];
	end

	// stage 2: q from lightness and saturation
	logic [F+9:0] ls_prod;
	logic [F+1:0] ls_t, s_fix, qv;
	always_comb begin
		ls_prod = (F+10)'(l_s1) * (F+10)'(cfg.sat);
		ls_t    = ls_prod[F+9:8];
		s_fix   = (F+2)'(cfg.sat) << (F-8);
		if (l_s1[F:F-1] == 2'b00) qv = (F+2)'(l_s1) + ls_t;
		else qv = (F+2)'(l_s1) + s_fix - ls_t;
	end

	// stage 3: p, spread and channel weights
	logic signed [F+2:0] pv;
	logic [F:0]          pcl;
	logic [8:0]          hr, hb, hr0;
	logic [9:0]          hb0;
	always_comb begin
		pv  = $signed({1'b0, l_s2, 1'b0}) - $signed({2'b00, q_s2});
		pcl = pv[F+2] ? '0 : pv[F:0];
		hr0 = cfg.hue + 9'd120;
		hb0 = 10'(cfg.hue) + 10'd240;
		hr  = (hr0 >= 9'd360) ? 9'(hr0 - 9'd360) : hr0;
		hb  = (hb0 >= 10'd360) ? 9'(hb0 - 10'd360) : hb0[8:0];
	end

	// stage 6: reciprocal quotient with one correction step
	logic [F:0]    q0   [3];
	logic [XW-1:0] rem6 [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			q0[c]   = y_s5[c][RECIP_SHIFT +: F+1];
			rem6[c] = x_s5[c] - (XW'({q0[c], 6'b0}) - XW'({q0[c], 2'b0}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			pix_s1 <= in_pix;
			l_s1   <= lcl;
		end
		if (ld2) begin
			pix_s2 <= pix_s1;
			l_s2   <= l_s1;
			q_s2   <= qv[F:0];
		end
		if (ld3) begin
			pix_s3  <= pix_s2;
			p_s3    <= pcl;
			d_s3    <= q_s2 - pcl;
			k_s3[0] <= hue_weight(hr);
			k_s3[1] <= hue_weight(cfg.hue);
			k_s3[2] <= hue_weight(hb);
		end
		if (ld4) begin
			pix_s4 <= pix_s3;
			p_s4   <= p_s3;
			for (int c = 0; c < 3; c++) x_s4[c] <= XW'(d_s3) * XW'(k_s3[c]);
		end
		if (ld5) begin
			pix_s5 <= pix_s4;
			p_s5   <= p_s4;
			for (int c = 0; c < 3; c++) begin
				x_s5[c] <= x_s4[c];
				y_s5[c] <= YW'(x_s4[c]) * YW'(RECIP_60);
			end
		end
		if (ld6) begin
			pix_s6 <= pix_s5;
			for (int c = 0; c < 3; c++) begin
				c_s6[c] <= p_s5 + q0[c] + (F+1)'(rem6[c] >= XW'(60));
			end
		end
	end

	assign out_valid = v_s6;
	assign out_pix   = pix_s6;
	assign out_col   = c_s6;

endmodule
`default_nettype wire

// ----- sv/hcp_blend.sv -----
// Re-premultiply and blend with the source pixel, two pipeline stages.
`default_nettype none
module hcp_blend import hcp_pkg::*; #(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [8:0]             weight,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire pix_t                   in_pix,
	input  wire logic [FRACTION_BITS:0] in_col [3],
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output pix_t                        out_pix
);

	localparam int unsigned F  = FRACTION_BITS;
	localparam int unsigned NW = F + 18;

	logic v_s1, v_s2, ld1, ld2;
	pix_t          pix_s1, pix_s2;
	logic [F+8:0]  ca_s1 [3];
	logic [15:0]   cw_s1 [3];

	logic [8:0]    wn;
	logic [7:0]    src  [3];
	logic [NW-1:0] num  [3];
	logic [7:0]    byt  [3];

	assign ld2 = !v_s2 || out_ready;
	assign ld1 = !v_s1 || ld2;
	assign in_ready = ld1;

	assign wn = 9'd256 - weight;

	always_comb begin
		src[0] = in_pix.red;
		src[1] = in_pix.green;
		src[2] = in_pix.blue;
		for (int c = 0; c < 3; c++) begin
			num[c] = NW'(ca_s1[c]) * NW'(weight) + (NW'(cw_s1[c]) << F);
			byt[c] = (pix_s1.alpha == 8'd0) ? 8'd0 : num[c][F+15:F+8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			pix_s1 <= in_pix;
			for (int c = 0; c < 3; c++) begin
				ca_s1[c] <= (F+9)'(in_col[c]) * (F+9)'(in_pix.alpha);
				cw_s1[c] <= 16'(src[c]) * 16'(wn);
			end
		end
		if (ld2) begin
			pix_s2.red   <= byt[0];
			pix_s2.green <= byt[1];
			pix_s2.blue  <= byt[2];
			pix_s2.alpha <= pix_s1.alpha;
		end
	end

	assign out_valid = v_s2;
	assign out_pix   = pix_s2;

endmodule
`default_nettype wire

// ----- sv/hsl_colorize_pixel_top.sv -----
// Top level of the HSL colorize pixel pipeline.
// Colorizes a stream of premultiplied RGBA8 pixels: keeps each pixel's
// lightness, shifts it, rebuilds color from a fixed hue and saturation,
// and blends the result with the source by the influence weight.
// Channels:
//   s_*   input items, tdata = {alpha, blue, green, red}, red in bits 7:0.
//   m_*   result items, same packing; alpha passes through.
//   cfg_* register writes, cfg_index 0 influence, 1 hue, 2 saturation,
//         3 lightness offset; always ready. Write only while idle.
// Pipeline: the divider, one quotient bit per stage, then the HSL and
// blend stages.
// Throughput: one item per cycle unless m_* stalls; every stage pipelined.
// Stall: each stage holds while the one after it is full and held, so
// bubbles fill in and s_tready drops only when every stage is occupied.
// Reset: all stages empty, registers return to influence 256, hue 180,
// saturation 128, offset 0.
`default_nettype none
module hsl_colorize_pixel_top import hcp_pkg::*; #(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // red_out, green_out, blue_out, alpha_out
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	localparam int unsigned F = FRACTION_BITS;

	logic [8:0] influence_q, hue_q, sat_q;
	logic [9:0] offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			influence_q <= 9'd256;
			hue_q       <= 9'd180;
			sat_q       <= 9'd128;
			offset_q    <= 10'd0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INFLUENCE:  influence_q <= cfg_data[8:0];
				CFG_HUE:        hue_q       <= cfg_data[8:0];
				CFG_SATURATION: sat_q       <= cfg_data[8:0];
				CFG_LIGHTNESS:  offset_q    <= cfg_data;
			endcase
		end
	end

	hsl_cfg_t   hcfg;
	logic [8:0] weight;
	always_comb begin
		hcfg.hue    = (hue_q >= 9'd360) ? 9'(hue_q - 9'd360) : hue_q;
		hcfg.sat    = (sat_q > 9'd256) ? 9'd256 : sat_q;
		hcfg.offset = offset_q;
		weight      = (influence_q > 9'd256) ? 9'd256 : influence_q;
	end

	pix_t       in_pix, u_pix, h_pix, o_pix;
	logic       u_valid, u_ready, h_valid, h_ready;
	logic [F:0] umax, umin;
	logic [F:0] col [3];

	assign in_pix = pix_t'(s_tdata);

	hcp_unpremul #(.FRACTION_BITS(FRACTION_BITS)) u_unpremul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pix    (in_pix),
		.out_valid (u_valid),
		.out_ready (u_ready),
		.out_pix   (u_pix),
		.out_umax  (umax),
		.out_umin  (umin)
	);

	hcp_hsl #(.FRACTION_BITS(FRACTION_BITS)) u_hsl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (hcfg),
		.in_valid  (u_valid),
		.in_ready  (u_ready),
		.in_pix    (u_pix),
		.in_umax   (umax),
		.in_umin   (umin),
		.out_valid (h_valid),
		.out_ready (h_ready),
		.out_pix   (h_pix),
		.out_col   (col)
	);

	hcp_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.weight    (weight),
		.in_valid  (h_valid),
		.in_ready  (h_ready),
		.in_pix    (h_pix),
		.in_col    (col),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (o_pix)
	);

	assign m_tdata = 32'(o_pix);

endmodule
`default_nettype wire

// ----- sv/hcp_checker.sv -----
// Port-level checks of the colorize pipeline and their bind to the top level.
`default_nettype none
module hcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:24] == 8'd0 |-> m_tdata[23:0] == 24'd0)
		else $error("transparent item with nonzero color");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input held off while output side drains");

endmodule

bind hsl_colorize_pixel_top hcp_checker u_hcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ----- sim/hcp_colorize_checker.sv -----
// Checker for the HSL colorize pipeline: predicts each result item and compares.
`timescale 1ns / 1ps
module hcp_colorize_checker import hcp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	output int               fail_count,
	output int               pending
);
	localparam int FB = 16;
	localparam longint ONE = longint'(1) << FB;
	localparam longint LSTEP = longint'(1) << (FB - 8);

	logic [8:0] influence_reg, hue_reg, sat_reg;
	logic [9:0] offset_reg;
	pix_t colorized_q[$];

	function automatic longint unpremul(longint c, longint a);
		longint u;
		u = (c << FB) / a;
		return (u > ONE) ? ONE : u;
	endfunction

	function automatic longint channel_level(int t, longint p, longint q);
		if (t < 60) return p + ((q - p) * t) / 60;
		if (t < 180) return q;
		if (t < 240) return p + ((q - p) * (240 - t)) / 60;
		return p;
	endfunction

	function automatic logic [7:0] mix_back(longint col, longint c, longint a, longint w);
		longint num;
		num = col * a * w + (c << FB) * (256 - w);
		return 8'(num / (longint'(256) << FB));
	endfunction

	function automatic pix_t colorize(pix_t px);
		pix_t r;
		longint a, mx, mn, l, off, s, q, p, w;
		int hue;
		r = '0;
		if (px.alpha == 0) return r;
		a = px.alpha;
		mx = px.red; mn = px.red;
		if (px.green > mx) mx = px.green;
		if (px.blue > mx) mx = px.blue;
		if (px.green < mn) mn = px.green;
		if (px.blue < mn) mn = px.blue;
		l = (unpremul(mx, a) + unpremul(mn, a)) >> 1;
		off = longint'($signed(offset_reg));
		l = l + off * LSTEP;
		if (l < 0) l = 0;
		if (l > ONE) l = ONE;
		s = ((sat_reg > 256) ? 256 : sat_reg) * LSTEP;
		if (l < ONE / 2) q = l + (l * s) / ONE;
		else q = l + s - (l * s) / ONE;
		p = 2 * l - q;
		if (p < 0) p = 0;
		hue = (hue_reg >= 360) ? hue_reg - 360 : hue_reg;
		w = (influence_reg > 256) ? 256 : influence_reg;
		r.red = mix_back(channel_level((hue + 120) % 360, p, q), px.red, a, w);
		r.green = mix_back(channel_level(hue, p, q), px.green, a, w);
		r.blue = mix_back(channel_level((hue + 240) % 360, p, q), px.blue, a, w);
		r.alpha = px.alpha;
		return r;
	endfunction

	assign pending = colorized_q.size();

	always @(posedge clk or negedge arst_n) begin
		pix_t got, want;
		if (!arst_n) begin
			influence_reg <= 9'd256;
			hue_reg <= 9'd180;
			sat_reg <= 9'd128;
			offset_reg <= '0;
			fail_count <= 0;
			colorized_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				colorized_q.push_back(colorize(pix_t'(s_tdata)));
			if (m_tvalid && m_tready) begin
				got = pix_t'(m_tdata);
				if (colorized_q.size() == 0) begin
					$display("%0t: unexpected item %h", $time, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = colorized_q.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue || got.alpha !== want.alpha) begin
						$display("%0t: mismatch expected r%h g%h b%h a%h, actual r%h g%h b%h a%h",
							$time, want.red, want.green, want.blue, want.alpha,
							got.red, got.green, got.blue, got.alpha);
						fail_count <= fail_count + 1;
					end
				end
			end
			// writes happen only while idle, so updating after the push is safe
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INFLUENCE: influence_reg <= cfg_data[8:0];
					CFG_HUE: hue_reg <= cfg_data[8:0];
					CFG_SATURATION: sat_reg <= cfg_data[8:0];
					CFG_LIGHTNESS: offset_reg <= cfg_data;
				endcase
			end
		end
	end
endmodule

// ----- sim/tb_hsl_colorize_pixel_top.sv -----
// Testbench top: stimulus, flow control and verdict for the HSL colorize pipeline.
`timescale 1ns / 1ps
module tb_hsl_colorize_pixel_top;
	import hcp_pkg::*;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [31:0] s_tdata = '0, m_tdata;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;
	int fail_count, pending;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_req = 0;
	int hold_cycles = 0;

	always #2 clk = ~clk;

	hsl_colorize_pixel_top uut (.*);
	hcp_colorize_checker chk (.*);

	// receiver flow control, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_cycles <= 300;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [9:0] val);
		logic rdy;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle;
		wait (pending == 0);
		repeat (40) @(posedge clk);
	endtask

	// valid stays high between back-to-back items; only dropped on a gap
	task automatic send_pixel(pix_t px);
		logic rdy;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic stop_sending;
		s_tvalid <= 1'b0;
	endtask

	function automatic pix_t random_pixel();
		pix_t px;
		int k;
		k = $urandom_range(99);
		px.alpha = (k < 5) ? 8'd0 : (k < 12) ? 8'd255 : 8'($urandom_range(1, 255));
		if (k >= 90 || px.alpha == 0) begin
			// colors not bounded by alpha
			px.red = 8'($urandom); px.green = 8'($urandom); px.blue = 8'($urandom);
		end else begin
			px.red = 8'($urandom_range(px.alpha));
			px.green = 8'($urandom_range(px.alpha));
			px.blue = 8'($urandom_range(px.alpha));
		end
		return px;
	endfunction

	task automatic apply_config(logic [9:0] infl, logic [9:0] hue, logic [9:0] sat,
			logic [9:0] off);
		write_reg(CFG_INFLUENCE, infl);
		write_reg(CFG_HUE, hue);
		write_reg(CFG_SATURATION, sat);
		write_reg(CFG_LIGHTNESS, off);
	endtask

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		pix_t directed[$];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed = '{32'h00000000, 32'hFFFFFFFF, 32'h00FFFFFF, 32'h00123456,
			32'hFF000000, 32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000,
			32'h80FFFFFF, 32'h01010101, 32'h01000000, 32'h80808080,
			32'h80404040, 32'h40FF0010, 32'hFF7F7F7F, 32'h80200010,
			32'hAA55AA55, 32'h55AA55AA};
		foreach (directed[i]) send_pixel(directed[i]);
		stop_sending();
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_config(10'd0, 10'd0, 10'd0, 10'h300);
				1: apply_config(10'd256, 10'd359, 10'd256, 10'd256);
				2: apply_config(10'h1FF, 10'h1FF, 10'h1FF, 10'h1FF);
				3: apply_config(10'd128, 10'd360, 10'd300, 10'h200);
				default: apply_config(10'($urandom_range(256)), 10'($urandom_range(359)),
					10'($urandom_range(256)), 10'($signed($urandom_range(512)) - 256));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				3: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			for (int n = 0; n < 135; n++) begin
				if (ph == 4 && n == 20) hold_req <= 1'b1;
				if (n == 70) begin
					stop_sending();
					wait (pending == 0);
				end
				send_pixel(random_pixel());
			end
			stop_sending();
			settle();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
